// ===== rtl/core/fsmatch_pkg.sv =====
// Shared types and constants for the first-substring-match block.
`default_nettype none
package fsmatch_pkg;

  // Fixed field and register widths
  localparam int unsigned TEXT_W    = 8;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned PAT_SEL_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic [TEXT_W-1:0] text_char;
    logic              last_char;
  } in_req_t;

  typedef struct packed {
    logic               match_found;
    logic [INDEX_W-1:0] match_index;
    logic               count_overflow;
  } out_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/fsmatch_cell.sv =====
// One window cell: holds a character and compares its next value to a pattern character.
`default_nettype none
module fsmatch_cell #(
  parameter int unsigned CHAR_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              shift_i,
  input  logic [CHAR_BITS-1:0]              char_i,
  input  logic [fsmatch_pkg::TEXT_W-1:0]    pat_i,
  input  logic                              active_i,
  output logic [CHAR_BITS-1:0]              char_o,
  output logic                              hit_o
);
  import fsmatch_pkg::*;

  logic [CHAR_BITS-1:0] char_q, char_d;

  assign char_d = shift_i ? char_i : char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else begin
      char_q <= char_d;
    end
  end

  // compare against the value entering this cell (window after the shift)
  assign hit_o  = !active_i || (char_i == CHAR_BITS'(pat_i));
  assign char_o = char_q;

endmodule
`default_nettype wire

// ===== rtl/core/fsmatch_pattern.sv =====
// Pattern registers, effective length and per-cell pattern character alignment.
`default_nettype none
module fsmatch_pattern #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              cfg_we_i,
  input  logic [fsmatch_pkg::CFG_IDX_W-1:0]                 cfg_idx_i,
  input  logic [fsmatch_pkg::CFG_W-1:0]                     cfg_data_i,
  output logic [fsmatch_pkg::LEN_W-1:0]                     eff_len_o,
  output logic [PATTERN_MAX-1:0][fsmatch_pkg::TEXT_W-1:0]   cell_pat_o,
  output logic [PATTERN_MAX-1:0]                            cell_active_o
);
  import fsmatch_pkg::*;

  logic [CFG_W-1:0] pat_low_q, pat_high_q;
  logic [LEN_W-1:0] pat_len_q;
  logic [PAT_BYTES-1:0][TEXT_W-1:0] pat_bytes;
  logic [LEN_W-1:0] lim;
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] sel_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        REG_PAT_HIGH: pat_high_q <= cfg_data_i;
        REG_PAT_LEN:  pat_len_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_bytes = {pat_high_q, pat_low_q};
  assign lim = (pat_len_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_q;

  // length stops at the first zero byte
  always_comb begin
    eff_len = lim;
    for (int k = PATTERN_MAX - 1; k >= 0; k--) begin
      if ((LEN_W'(k) < lim) && (pat_bytes[k] == '0)) begin
        eff_len = LEN_W'(k);
      end
    end
  end

  // cell i holds the character that lines up with pattern position len-1-i
  always_comb begin
    sel_full = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      sel_full         = eff_len - LEN_W'(i) - LEN_W'(1);
      cell_pat_o[i]    = pat_bytes[sel_full[PAT_SEL_W-1:0]];
      cell_active_o[i] = LEN_W'(i) < eff_len;
    end
  end

  assign eff_len_o = eff_len;

endmodule
`default_nettype wire

// ===== rtl/core/first_substring_match.sv =====
// Top level of the streaming first-substring-match block.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------------
//   input    | in_valid_i / in_ready_o  | in_req_i  : text_char, last_char
//   output   | out_valid_o / out_ready_i| out_req_o : match_found, match_index,
//            |                          |             count_overflow
//   config   | cfg_we_i (no wait)       | cfg_idx_i, cfg_data_i
//
// One character per cycle. A row of PATTERN_MAX cells shifts the window and
// compares all positions in the same cycle; the result of a text shows in the
// output register the cycle after its last character is taken.
// Input stalls only while a result sits in the output register and is not taken.
// Reset clears pattern registers, window, per-text state and the output valid.
`default_nettype none
module first_substring_match #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned CHAR_BITS   = 8,
  parameter int unsigned INDEX_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  fsmatch_pkg::in_req_t              in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output fsmatch_pkg::out_req_t             out_req_o,
  input  logic                              cfg_we_i,
  input  logic [fsmatch_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fsmatch_pkg::CFG_W-1:0]     cfg_data_i
);
  import fsmatch_pkg::*;

  // position counter holds one bit more than the index, so that starts past
  // the index range are detected by its top bit
  localparam int unsigned SEEN_W = INDEX_BITS + 1;
  localparam logic [SEEN_W-1:0] SEEN_CAP =
    SEEN_W'((64'd1 << INDEX_BITS) + 64'(PATTERN_MAX));

  logic [LEN_W-1:0]                       eff_len;
  logic [PATTERN_MAX-1:0][TEXT_W-1:0]     cell_pat;
  logic [PATTERN_MAX-1:0]                 cell_active;
  logic [PATTERN_MAX-1:0][CHAR_BITS-1:0]  cell_in;
  logic [PATTERN_MAX-1:0][CHAR_BITS-1:0]  cell_q;
  logic [PATTERN_MAX-1:0]                 cell_hit;

  logic accept, char_zero, take_char, last;
  logic [SEEN_W-1:0] seen_q, seen_d, seen_new, start;
  logic hit_q, hit_d, ended_q, ended_d, sat_q, sat_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic check;

  logic     out_valid_q, out_valid_d;
  out_req_t out_q, out_d;

  fsmatch_pattern #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_pattern (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .eff_len_o    (eff_len),
    .cell_pat_o   (cell_pat),
    .cell_active_o(cell_active)
  );

  // request handshake; input waits only while a held result is not taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign char_zero  = (in_req_i.text_char == '0);
  assign take_char  = accept && !ended_q && !char_zero;
  assign last       = in_req_i.last_char;

  // window chain, newest character enters cell 0
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_in[i] = CHAR_BITS'(in_req_i.text_char);
    end else begin : g_body
      assign cell_in[i] = cell_q[i-1];
    end
    fsmatch_cell #(
      .CHAR_BITS(CHAR_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (take_char),
      .char_i  (cell_in[i]),
      .pat_i   (cell_pat[i]),
      .active_i(cell_active[i]),
      .char_o  (cell_q[i]),
      .hit_o   (cell_hit[i])
    );
  end

  assign seen_new = (seen_q < SEEN_CAP) ? seen_q + SEEN_W'(1) : seen_q;
  assign start    = seen_new - SEEN_W'(eff_len);
  assign check    = take_char && !hit_q && (eff_len != '0) &&
                    (seen_new >= SEEN_W'(eff_len));

  // per-text state after this character
  always_comb begin
    seen_d  = seen_q;
    hit_d   = hit_q;
    idx_d   = idx_q;
    ended_d = ended_q;
    sat_d   = sat_q;
    if (accept && !ended_q && char_zero) begin
      ended_d = 1'b1;
    end
    if (take_char) begin
      seen_d = seen_new;
    end
    if (check) begin
      if (start[SEEN_W-1]) begin
        sat_d = 1'b1;
      end else if (&cell_hit) begin
        hit_d = 1'b1;
        idx_d = start[INDEX_BITS-1:0];
      end
    end
  end

  // result from the state after the last character
  always_comb begin
    out_d.match_found    = hit_d;
    out_d.match_index    = hit_d ? INDEX_W'(idx_d) : '0;
    out_d.count_overflow = sat_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      hit_q       <= 1'b0;
      idx_q       <= '0;
      ended_q     <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept && last) begin
        seen_q  <= '0;
        hit_q   <= 1'b0;
        idx_q   <= '0;
        ended_q <= 1'b0;
        sat_q   <= 1'b0;
      end else begin
        seen_q  <= seen_d;
        hit_q   <= hit_d;
        idx_q   <= idx_d;
        ended_q <= ended_d;
        sat_q   <= sat_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule
`default_nettype wire
